// ===== sv/sem_pkg.sv =====
// Shared types, constants and square-root step for the Sobel edge magnitude block.
package sem_pkg;

  // Field and register widths
  localparam int PIXEL_W    = 8;
  localparam int WIDTH_CFG_W = 12;
  localparam int HEIGHT_W   = 16;
  localparam int ROW_W      = HEIGHT_W + 1;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int GRAD_W     = 11;
  localparam int SUMSQ_W    = 21;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  // Operation codes of an input request
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // One request for the back: masked 3x3 neighbourhood, row-major
  typedef struct packed {
    logic [2:0][2:0][PIXEL_W-1:0] taps;
    logic                         last;
  } tap_req_t;

  // Partial state of the digit-by-digit square root
  typedef struct packed {
    logic [9:0] rem;
    logic [7:0] root;
  } sq_state_t;

  // One restoring square-root step: bring down two bits, try to subtract
  function automatic sq_state_t sqrt_step(input sq_state_t s, input logic [1:0] pair);
    logic [11:0] acc;
    logic [11:0] trial;
    sq_state_t   res;
    acc   = {s.rem, pair};
    trial = {2'b00, s.root, 2'b01};
    if (acc >= trial) begin
      res.rem  = 10'(acc - trial);
      res.root = {s.root[6:0], 1'b1};
    end else begin
      res.rem  = 10'(acc);
      res.root = {s.root[6:0], 1'b0};
    end
    return res;
  endfunction

endpackage

// ===== sv/sem_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and read port returning old data on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/sem_front.sv =====
// Front end: configuration, raster counters, line stores and 3x3 window.
module sem_front #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [sem_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sem_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              operation,
  input  logic [sem_pkg::PIXEL_W-1:0]       pixel_value,
  input  logic [sem_pkg::QUEUE_CW-1:0]      queue_count,
  output logic                              push,
  output sem_pkg::tap_req_t                 push_data
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (WW > sem_pkg::WIDTH_CFG_W) ? WW : sem_pkg::WIDTH_CFG_W;
  localparam int PW   = sem_pkg::PIXEL_W;
  localparam int RW   = sem_pkg::ROW_W;

  logic [sem_pkg::WIDTH_CFG_W-1:0] cfg_width;
  logic [sem_pkg::HEIGHT_W-1:0]    cfg_height;
  logic [CW-1:0]                   col;
  logic [CW-1:0]                   col_next;
  logic [RW-1:0]                   row;
  logic [RW-1:0]                   row_next;

  logic [CMPW-1:0]                 wid_ext;
  logic [WW-1:0]                   w_eff;
  logic [sem_pkg::HEIGHT_W-1:0]    h_eff;
  logic [RW-1:0]                   h_ext;
  logic [RW-1:0]                   h_p1;
  logic [RW-1:0]                   h_p2;
  logic [WW-1:0]                   col_ext;
  logic [WW-1:0]                   col_inc;
  logic                            accept;
  logic                            at_edge;
  logic                            emit;
  logic                            last;
  logic [3:0]                      mask;
  logic [PW-1:0]                   v;
  logic [sem_pkg::QUEUE_CW-1:0]    occupancy;

  // Second front stage: line-store data arrives here
  logic                            f1_valid;
  logic [CW-1:0]                   f1_addr;
  logic [PW-1:0]                   f1_v;
  logic                            f1_ra;
  logic                            f1_rb;
  logic                            f1_edge;
  logic                            f1_emit;
  logic                            f1_last;
  logic [3:0]                      f1_mask;
  logic                            fwd;
  logic [PW-1:0]                   fwd_above;
  logic [PW-1:0]                   fwd_two;
  logic [PW-1:0]                   above_q;
  logic [PW-1:0]                   two_q;
  logic [PW-1:0]                   a_cur;
  logic [PW-1:0]                   b_cur;

  logic [2:0][2:0][PW-1:0]         win;
  logic [2:0][2:0][PW-1:0]         shifted;
  logic [2:0][2:0][PW-1:0]         taps;
  logic [2:0][2:0][PW-1:0]         masked;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= sem_pkg::WIDTH_CFG_W'(512);
      cfg_height <= sem_pkg::HEIGHT_W'(512);
    end else if (cfg_write) begin
      unique case (cfg_index)
        sem_pkg::REG_WIDTH:  cfg_width  <= cfg_data[sem_pkg::WIDTH_CFG_W-1:0];
        sem_pkg::REG_HEIGHT: cfg_height <= cfg_data[sem_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the image size into the supported range
  always_comb begin
    wid_ext = CMPW'(cfg_width);
    if (cfg_width == '0) begin
      w_eff = WW'(1);
    end else if (wid_ext > CMPW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(wid_ext);
    end
    h_eff = (cfg_height == '0) ? sem_pkg::HEIGHT_W'(1) : cfg_height;
    h_ext = RW'(h_eff);
    h_p1  = h_ext + RW'(1);
    h_p2  = h_ext + RW'(2);
  end

  // Hold requests while the queue could overflow
  assign occupancy = queue_count + sem_pkg::QUEUE_CW'(f1_valid);
  assign in_stall  = occupancy >= sem_pkg::QUEUE_CW'(sem_pkg::QUEUE_DEPTH);
  assign accept    = in_valid && !in_stall;

  // Classify the request: which position gets a result, and its borders
  always_comb begin
    col_ext = WW'(col);
    col_inc = col_ext + WW'(1);
    at_edge = (col == '0);
    if (at_edge) begin
      emit    = (row >= RW'(2)) && (row < h_p2);
      last    = (row == h_p1);
      mask[0] = (row >= RW'(3));
      mask[1] = (row != h_p1);
      mask[2] = (w_eff >= WW'(2));
      mask[3] = 1'b0;
    end else begin
      emit    = (row >= RW'(1)) && (row <= h_ext) && (col_ext <= w_eff);
      last    = (row == h_ext) && (col_ext == w_eff);
      mask[0] = (row >= RW'(2));
      mask[1] = (row != h_ext);
      mask[2] = (col_ext >= WW'(2));
      mask[3] = (col_ext != w_eff);
    end
    v = ((operation == sem_pkg::OP_FLUSH) || (row >= h_ext)) ? '0 : pixel_value;

    // Advance the raster position; restart after the final result
    if (emit && last) begin
      col_next = '0;
      row_next = '0;
    end else if (col_inc >= w_eff) begin
      col_next = '0;
      row_next = (row < h_p2) ? row + RW'(1) : row;
    end else begin
      col_next = CW'(col_inc);
      row_next = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= accept;
      if (accept) begin
        col <= col_next;
        row <= row_next;
      end
    end
  end

  // Capture the request for the second stage
  always_ff @(posedge clk) begin
    if (accept) begin
      f1_addr   <= col;
      f1_v      <= v;
      f1_ra     <= (row >= RW'(1));
      f1_rb     <= (row >= RW'(2));
      f1_edge   <= at_edge;
      f1_emit   <= emit;
      f1_last   <= last;
      f1_mask   <= mask;
      fwd       <= f1_valid && (f1_addr == col);
      fwd_above <= f1_v;
      fwd_two   <= a_cur;
    end
  end

  // Line stores: read at acceptance, written in the following cycle from the second stage
  sem_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_line_above (
    .clk   (clk),
    .we    (f1_valid),
    .waddr (f1_addr),
    .wdata (f1_v),
    .re    (accept),
    .raddr (col),
    .rdata (above_q)
  );

  sem_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_line_two_above (
    .clk   (clk),
    .we    (f1_valid),
    .waddr (f1_addr),
    .wdata (a_cur),
    .re    (accept),
    .raddr (col),
    .rdata (two_q)
  );

  // Bypass a write that landed on the same entry in the read cycle
  always_comb begin
    a_cur = f1_ra ? (fwd ? fwd_above : above_q) : '0;
    b_cur = f1_rb ? (fwd ? fwd_two : two_q) : '0;
  end

  // Shift the window and pick the neighbourhood for this position
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shifted[i][0] = win[i][1];
      shifted[i][1] = win[i][2];
    end
    shifted[0][2] = b_cur;
    shifted[1][2] = a_cur;
    shifted[2][2] = f1_v;

    for (int i = 0; i < 3; i++) begin
      if (f1_edge) begin
        taps[i][0] = win[i][1];
        taps[i][1] = win[i][2];
        taps[i][2] = '0;
      end else begin
        taps[i] = shifted[i];
      end
    end

    // Drop neighbours that lie outside the image
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if ((i == 0 && !f1_mask[0]) || (i == 2 && !f1_mask[1]) ||
            (j == 0 && !f1_mask[2]) || (j == 2 && !f1_mask[3])) begin
          masked[i][j] = '0;
        end else begin
          masked[i][j] = taps[i][j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (f1_valid) begin
      if (f1_emit && f1_last) begin
        win <= '0;
      end else begin
        win <= shifted;
      end
    end
  end

  assign push           = f1_valid && f1_emit;
  assign push_data.taps = masked;
  assign push_data.last = f1_last;

endmodule

// ===== sv/sem_queue.sv =====
// Short queue of neighbourhood requests between front and back.
module sem_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  sem_pkg::tap_req_t             push_data,
  input  logic                          pop,
  output sem_pkg::tap_req_t             head,
  output logic                          empty,
  output logic [sem_pkg::QUEUE_CW-1:0]  count
);

  sem_pkg::tap_req_t                entries [sem_pkg::QUEUE_DEPTH];
  logic [sem_pkg::QUEUE_AW-1:0]     wr_ptr;
  logic [sem_pkg::QUEUE_AW-1:0]     rd_ptr;

  // Store entries; the front never pushes into a full queue
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + sem_pkg::QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + sem_pkg::QUEUE_AW'(1);
      end
      count <= count + sem_pkg::QUEUE_CW'(push) - sem_pkg::QUEUE_CW'(pop);
    end
  end

  assign head  = entries[rd_ptr];
  assign empty = (count == '0);

endmodule

// ===== sv/sem_back.sv =====
// Back end: Sobel sums, squared magnitude, square root and output register.
module sem_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  input  sem_pkg::tap_req_t            head,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sem_pkg::PIXEL_W-1:0]  edge_magnitude,
  output logic                         last_pixel
);

  localparam int GW = sem_pkg::GRAD_W;

  logic                              advance;

  logic signed [GW-1:0]              gx;
  logic signed [GW-1:0]              gy;
  logic signed [GW-1:0]              e [3][3];

  logic                              s1_valid;
  logic                              s1_last;
  logic signed [GW-1:0]              s1_gx;
  logic signed [GW-1:0]              s1_gy;

  logic signed [2*GW-1:0]            gx2;
  logic signed [2*GW-1:0]            gy2;
  logic [2*GW-1:0]                   sum_sq;

  logic                              s2_valid;
  logic                              s2_last;
  logic [sem_pkg::SUMSQ_W-1:0]       s2_sq;

  sem_pkg::sq_state_t                hi_state;
  logic                              s3_valid;
  logic                              s3_last;
  logic                              s3_sat;
  logic [7:0]                        s3_low;
  sem_pkg::sq_state_t                s3_state;

  sem_pkg::sq_state_t                lo_state;

  // Move the whole back pipeline unless the result register is held
  assign advance = !(out_valid && out_stall);
  assign pop     = advance && !q_empty;

  // Gradient sums over the masked neighbourhood
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        e[i][j] = $signed({3'b000, head.taps[i][j]});
      end
    end
    gx = (e[0][2] - e[0][0]) + ((e[1][2] - e[1][0]) <<< 1) + (e[2][2] - e[2][0]);
    gy = (e[2][0] - e[0][0]) + ((e[2][1] - e[0][1]) <<< 1) + (e[2][2] - e[0][2]);
  end

  // Sum of squares
  always_comb begin
    gx2    = s1_gx * s1_gx;
    gy2    = s1_gy * s1_gy;
    sum_sq = unsigned'(gx2) + unsigned'(gy2);
  end

  // First four root digits from the upper byte
  always_comb begin
    hi_state = '0;
    for (int k = 0; k < 4; k++) begin
      hi_state = sem_pkg::sqrt_step(hi_state, s2_sq[15-2*k -: 2]);
    end
  end

  // Last four root digits from the lower byte
  always_comb begin
    lo_state = s3_state;
    for (int k = 0; k < 4; k++) begin
      lo_state = sem_pkg::sqrt_step(lo_state, s3_low[7-2*k -: 2]);
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= pop;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_gx          <= gx;
      s1_gy          <= gy;
      s1_last        <= head.last;
      s2_sq          <= sem_pkg::SUMSQ_W'(sum_sq);
      s2_last        <= s1_last;
      s3_state       <= hi_state;
      s3_low         <= s2_sq[7:0];
      s3_sat         <= (s2_sq[sem_pkg::SUMSQ_W-1:16] != '0);
      s3_last        <= s2_last;
      edge_magnitude <= s3_sat ? 8'hFF : lo_state.root;
      last_pixel     <= s3_last;
    end
  end

endmodule

// ===== sv/sobel_edge_magnitude_core.sv =====
// Top level of the streaming 3x3 Sobel gradient magnitude block.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------
//   cfg      | cfg_write            | cfg_index, cfg_data
//   in       | in_valid / in_stall  | operation, pixel_value
//   out      | out_valid / out_stall| edge_magnitude, last_pixel
//
// One request a cycle is taken when the back keeps up; the front issues both
// line-store reads at acceptance, so each line store is touched once per
// request on its single write and single read port.
// A result leaves the back pipeline after the request that completes its 3x3
// neighbourhood (width + 1 raster positions after its own pixel).
// Reset is synchronous; line stores are not cleared and first-row reads are
// masked. in_stall rises when the four-entry queue could fill; out_stall
// freezes the back pipeline and the queue absorbs the difference.
module sobel_edge_magnitude_core #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           operation,
  input  logic [sem_pkg::PIXEL_W-1:0]    pixel_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [sem_pkg::PIXEL_W-1:0]    edge_magnitude,
  output logic                           last_pixel
);

  logic                          push;
  sem_pkg::tap_req_t             push_data;
  logic                          pop;
  sem_pkg::tap_req_t             head;
  logic                          q_empty;
  logic [sem_pkg::QUEUE_CW-1:0]  queue_count;

  // Accept and classify pixels, build neighbourhoods
  sem_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .pixel_value (pixel_value),
    .queue_count (queue_count),
    .push        (push),
    .push_data   (push_data)
  );

  // Decouple front and back
  sem_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .count     (queue_count)
  );

  // Compute the magnitude
  sem_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .edge_magnitude (edge_magnitude),
    .last_pixel     (last_pixel)
  );

endmodule
